/* rtl/blemp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blemp_pkg
// Shared types and constants of the BLE MIDI message parser.
// ----------------------------------------------------------------------------
package blemp_pkg;

  localparam int unsigned QueueDepth = 2;

  localparam logic [3:0] StatusNoteOn     = 4'b1001;
  localparam logic [3:0] StatusNoteOff    = 4'b1000;
  localparam logic [3:0] StatusPitchBend  = 4'b1110;
  localparam logic [3:0] StatusCtrlChange = 4'b1011;
  localparam logic [7:0] LowNibbleMask    = 8'h0F;

  localparam logic CfgFilterEnable = 1'b0;
  localparam logic CfgFilterChan   = 1'b1;

  typedef enum logic [1:0] {
    KindNoteOn     = 2'd0,
    KindNoteOff    = 2'd1,
    KindPitchBend  = 2'd2,
    KindCtrlChange = 2'd3
  } kind_e;

  typedef struct packed {
    logic [3:0] status;
    logic [3:0] chan;
    logic [6:0] first_data;
    logic [6:0] second_data;
  } msg_t;

  typedef struct packed {
    logic       enable;
    logic [3:0] chan;
  } filter_t;

endpackage

/* rtl/blemp_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blemp_front
// Byte parser: holds one byte of lookahead, tracks running status per packet
// and forms raw messages for the back end.
// ----------------------------------------------------------------------------
module blemp_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        data_byte_i,
  input  logic              packet_end_i,
  output logic              msg_valid_o,
  output blemp_pkg::msg_t   msg_o
);

  typedef enum logic [1:0] {
    PendNone = 2'd0,
    PendHigh = 2'd1,
    PendData = 2'd2
  } pend_e;

  pend_e      pend_q, pend_d;
  logic [7:0] pval_q, pval_d;
  logic [3:0] rs_q, rs_d;
  logic [3:0] rc_q, rc_d;

  logic       is_data;
  logic [3:0] rs_eff;
  logic [3:0] rc_eff;
  logic       emit;

  always_comb begin
    is_data = ~data_byte_i[7];
    rs_eff  = rs_q;
    rc_eff  = rc_q;
    if (pend_q == PendHigh && is_data) begin
      rs_eff = pval_q[7:4];
      rc_eff = pval_q[3:0] & blemp_pkg::LowNibbleMask[3:0];
    end

    emit              = 1'b0;
    msg_o.status      = rs_eff;
    msg_o.chan        = rc_eff;
    msg_o.first_data  = pval_q[6:0];
    msg_o.second_data = is_data ? data_byte_i[6:0] : 7'd0;
    if (pend_q == PendData) begin
      emit = 1'b1;
    end else if (packet_end_i && is_data) begin
      emit              = 1'b1;
      msg_o.first_data  = data_byte_i[6:0];
      msg_o.second_data = 7'd0;
    end
    msg_valid_o = accept_i && emit;

    if (pend_q == PendData && is_data) begin
      pend_d = PendNone;
    end else begin
      pend_d = is_data ? PendData : PendHigh;
    end
    pval_d = data_byte_i;
    rs_d   = rs_eff;
    rc_d   = rc_eff;
    if (packet_end_i) begin
      pend_d = PendNone;
      rs_d   = 4'd0;
      rc_d   = 4'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= PendNone;
      rs_q   <= 4'd0;
      rc_q   <= 4'd0;
    end else if (accept_i) begin
      pend_q <= pend_d;
      rs_q   <= rs_d;
      rc_q   <= rc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      pval_q <= pval_d;
    end
  end

endmodule

/* rtl/blemp_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blemp_queue
// Short register queue of raw messages between the parser and the back end.
// ----------------------------------------------------------------------------
module blemp_queue #(
  parameter int unsigned Depth = blemp_pkg::QueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  blemp_pkg::msg_t wdata_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            empty_o,
  output blemp_pkg::msg_t rdata_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  blemp_pkg::msg_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push;
  logic            do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

/* rtl/blemp_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blemp_back
// Decodes the message kind, applies the channel filter and holds the result
// in an output register.
// ----------------------------------------------------------------------------
module blemp_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  blemp_pkg::filter_t filter_i,
  input  logic               msg_valid_i,
  input  blemp_pkg::msg_t    msg_i,
  output logic               msg_take_o,
  input  logic               pop_i,
  output logic               out_valid_o,
  output logic [1:0]         message_kind_o,
  output logic [3:0]         chan_o,
  output logic [6:0]         first_data_o,
  output logic [6:0]         second_data_o
);

  logic                  valid_q, valid_d;
  blemp_pkg::kind_e      kind_q, kind_d;
  logic [3:0]            chan_q;
  logic [6:0]            d1_q;
  logic [6:0]            d2_q, d2_d;
  logic                  supported;
  logic                  passes;

  always_comb begin
    supported = 1'b1;
    kind_d    = blemp_pkg::KindNoteOn;
    d2_d      = msg_i.second_data;
    unique case (msg_i.status)
      blemp_pkg::StatusNoteOn:     kind_d = blemp_pkg::KindNoteOn;
      blemp_pkg::StatusNoteOff:    kind_d = blemp_pkg::KindNoteOff;
      blemp_pkg::StatusPitchBend: begin
        kind_d = blemp_pkg::KindPitchBend;
        d2_d   = 7'd0;
      end
      blemp_pkg::StatusCtrlChange: kind_d = blemp_pkg::KindCtrlChange;
      default:                     supported = 1'b0;
    endcase
    passes     = supported && (!filter_i.enable || msg_i.chan == filter_i.chan);
    msg_take_o = msg_valid_i && (!valid_q || pop_i);
    valid_d    = valid_q;
    if (msg_take_o) begin
      valid_d = passes;
    end else if (pop_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (msg_take_o && passes) begin
      kind_q <= kind_d;
      chan_q <= msg_i.chan;
      d1_q   <= msg_i.first_data;
      d2_q   <= d2_d;
    end
  end

  assign out_valid_o    = valid_q;
  assign message_kind_o = kind_q;
  assign chan_o         = chan_q;
  assign first_data_o   = d1_q;
  assign second_data_o  = d2_q;

endmodule

/* rtl/ble_midi_message_parser_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ble_midi_message_parser_unit
// Parses BLE MIDI packet bytes into note on, note off, pitch bend and control
// change messages with an optional channel filter.
// ----------------------------------------------------------------------------
// One packet byte is taken per clock cycle while full is low. A message
// caused by a byte passes the message queue and then the output register
// before it reaches the result ports. The queue decouples input and result
// sides, so full rises only once QueueDepth messages wait in it because the
// result side stalls. Filter settings are written through the configuration
// port only while the block is idle: a rule for the user, not enforced.
// ----------------------------------------------------------------------------
module ble_midi_message_parser_unit #(
  parameter int unsigned QueueDepth = blemp_pkg::QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte_i,
  input  logic       packet_end_i,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] message_kind_o,
  output logic [3:0] chan_o,
  output logic [6:0] first_data_o,
  output logic [6:0] second_data_o,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [3:0] cfg_wdata_i
);

  blemp_pkg::filter_t filter_q;
  blemp_pkg::msg_t    front_msg;
  blemp_pkg::msg_t    head_msg;
  logic               front_valid;
  logic               accept;
  logic               q_empty;
  logic               q_take;
  logic               out_valid;

  assign accept = push && !full;
  assign empty  = !out_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        blemp_pkg::CfgFilterEnable: filter_q.enable <= cfg_wdata_i[0];
        blemp_pkg::CfgFilterChan:   filter_q.chan   <= cfg_wdata_i;
        default:                    filter_q        <= filter_q;
      endcase
    end
  end

  blemp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .data_byte_i  (data_byte_i),
    .packet_end_i (packet_end_i),
    .msg_valid_o  (front_valid),
    .msg_o        (front_msg)
  );

  blemp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid),
    .wdata_i (front_msg),
    .pop_i   (q_take),
    .full_o  (full),
    .empty_o (q_empty),
    .rdata_o (head_msg)
  );

  blemp_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .filter_i       (filter_q),
    .msg_valid_i    (!q_empty),
    .msg_i          (head_msg),
    .msg_take_o     (q_take),
    .pop_i          (pop),
    .out_valid_o    (out_valid),
    .message_kind_o (message_kind_o),
    .chan_o         (chan_o),
    .first_data_o   (first_data_o),
    .second_data_o  (second_data_o)
  );

endmodule
